// ===== hw/rtl/average_predictor_raster_decode_defines.svh =====
// Assertion macros shared by the average predictor decode RTL
`ifndef AVERAGE_PREDICTOR_RASTER_DECODE_DEFINES_SVH
`define AVERAGE_PREDICTOR_RASTER_DECODE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define APR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("apr: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define APR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("apr: next-cycle check failed");

`endif

// ===== hw/rtl/apr_pkg.sv =====
// Shared types and constants of the average predictor decode block
package apr_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int APB_AW        = 4;
	localparam int APB_DW        = 32;
	localparam int CMD_DEPTH     = 4;
	localparam int RES_DEPTH     = 2;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_PAD_ODD_ROWS = 2'd2
	} reg_idx_t;

	// which predictor a sample uses
	typedef enum logic [1:0] {
		KIND_FIRST,
		KIND_TOP_ROW,
		KIND_LEFT_COL,
		KIND_INNER
	} kind_t;

	// classified sample from the front end (column index travels alongside)
	typedef struct packed {
		logic [7:0] residual;
		kind_t      kind;
		logic       eor;
		logic       eof;
	} cmd_t;

	// reconstructed result beat
	typedef struct packed {
		logic [7:0] sample;
		logic       eor;
		logic       eof;
	} res_t;

endpackage

// ===== hw/rtl/apr_fifo.sv =====
// Small register FIFO used for the command and result queues
`include "average_predictor_raster_decode_defines.svh"
module apr_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          push_ok;
	logic          pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign dout    = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`APR_ASSERT_NEXT(a_fifo_fills, clk, arst_n, push_ok && !pop_ok && (cnt_q == CW'(DEPTH - 1)), full)

endmodule

// ===== hw/rtl/apr_front.sv =====
// Front end: takes residual beats, tracks raster position, drops pad bytes
`include "average_predictor_raster_decode_defines.svh"
module apr_front #(
	parameter int MAX_WIDTH = apr_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [7:0]                     residual,
	output logic                           full,
	input  logic [12:0]                    image_width,
	input  logic [15:0]                    image_height,
	input  logic                           pad_odd_rows,
	output logic                           cmd_push,
	output apr_pkg::cmd_t                  cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]   cmd_xi,
	input  logic                           cmd_full
);
	import apr_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = (XW + 1 > 13) ? XW + 1 : 13;

	logic [XW-1:0] col_q;
	logic [15:0]   row_q;
	logic          pad_q;
	logic          accept;
	logic [WW-1:0] width_w;
	logic [WW-1:0] last_col;
	logic          width_odd;
	logic [15:0]   last_row;
	logic          eor_c;
	logic          eof_c;
	kind_t         kind_c;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// effective width: zero acts as one, clipped to the line store size
	assign width_w = WW'(image_width);
	always_comb begin
		if (image_width == '0) begin
			last_col  = '0;
			width_odd = 1'b1;
		end else if (width_w > WW'(MAX_WIDTH)) begin
			last_col  = WW'(MAX_WIDTH - 1);
			width_odd = MAX_WIDTH[0];
		end else begin
			last_col  = width_w - 1'b1;
			width_odd = image_width[0];
		end
	end

	assign last_row = (image_height == '0) ? '0 : image_height - 1'b1;
	assign eor_c    = (WW'(col_q) >= last_col);
	assign eof_c    = eor_c && (row_q >= last_row);

	// predictor selection
	always_comb begin
		priority if (col_q == '0 && row_q == '0) begin
			kind_c = KIND_FIRST;
		end else if (row_q == '0) begin
			kind_c = KIND_TOP_ROW;
		end else if (col_q == '0) begin
			kind_c = KIND_LEFT_COL;
		end else begin
			kind_c = KIND_INNER;
		end
	end

	assign cmd_push     = accept && !pad_q;
	assign cmd.residual = residual;
	assign cmd.kind     = kind_c;
	assign cmd.eor      = eor_c;
	assign cmd.eof      = eof_c;
	assign cmd_xi       = col_q;

	// raster position and pad tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pad_q <= 1'b0;
		end else if (accept) begin
			if (pad_q) begin
				pad_q <= 1'b0;
			end else if (eor_c) begin
				col_q <= '0;
				row_q <= eof_c ? '0 : row_q + 1'b1;
				pad_q <= pad_odd_rows && width_odd;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	`APR_ASSERT_NOW(a_pad_dropped, clk, arst_n, accept && pad_q, !cmd_push)
	`APR_ASSERT_NEXT(a_frame_wrap, clk, arst_n, cmd_push && eof_c, (col_q == '0) && (row_q == '0))

endmodule

// ===== hw/rtl/apr_back.sv =====
// Back end: line store lookup, prediction and reconstruction
`include "average_predictor_raster_decode_defines.svh"
module apr_back #(
	parameter int MAX_WIDTH = apr_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  apr_pkg::cmd_t                cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0] cmd_xi,
	input  logic                         cmd_empty,
	output logic                         cmd_pop,
	output logic                         res_push,
	output apr_pkg::res_t                res,
	input  logic                         res_full
);
	import apr_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);

	logic [7:0]    line_mem [MAX_WIDTH];
	logic          vld_s2;
	cmd_t          cmd_s2;
	logic [XW-1:0] xi_s2;
	logic [7:0]    rd_s2;
	logic          byp_s2;
	logic [7:0]    bypd_s2;
	logic [7:0]    left_q;
	logic          adv;
	logic          issue;
	logic [7:0]    top_c;
	logic [8:0]    sum_c;
	logic [7:0]    sample_c;

	assign adv     = vld_s2 && !res_full;
	assign issue   = !cmd_empty && (!vld_s2 || adv);
	assign cmd_pop = issue;

	// line store: read at issue, written when a sample retires
	always_ff @(posedge clk) begin
		if (adv) begin
			line_mem[xi_s2] <= sample_c;
		end
		if (issue) begin
			rd_s2 <= line_mem[cmd_xi];
		end
	end

	// stage 2 payload; forward when the previous sample hits the same column
	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s2  <= cmd;
			xi_s2   <= cmd_xi;
			byp_s2  <= vld_s2 && (xi_s2 == cmd_xi);
			bypd_s2 <= sample_c;
		end
	end

	// stage 2 valid and left neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			left_q <= '0;
		end else begin
			if (issue) begin
				vld_s2 <= 1'b1;
			end else if (adv) begin
				vld_s2 <= 1'b0;
			end
			if (adv) begin
				left_q <= sample_c;
			end
		end
	end

	// reconstruction, all modulo 256
	assign top_c = byp_s2 ? bypd_s2 : rd_s2;
	assign sum_c = {1'b0, left_q} + {1'b0, top_c};
	always_comb begin
		unique case (cmd_s2.kind)
			KIND_FIRST:    sample_c = cmd_s2.residual;
			KIND_TOP_ROW:  sample_c = left_q - cmd_s2.residual;
			KIND_LEFT_COL: sample_c = top_c - cmd_s2.residual;
			KIND_INNER:    sample_c = sum_c[8:1] - cmd_s2.residual;
			default:       sample_c = cmd_s2.residual;
		endcase
	end

	assign res_push   = adv;
	assign res.sample = sample_c;
	assign res.eor    = cmd_s2.eor;
	assign res.eof    = cmd_s2.eof;

	`APR_ASSERT_NOW(a_issue_free, clk, arst_n, issue && vld_s2, adv)
	`APR_ASSERT_NEXT(a_first_left, clk, arst_n, adv && (cmd_s2.kind == KIND_FIRST), left_q == $past(cmd_s2.residual))

endmodule

// ===== hw/rtl/average_predictor_raster_decode.sv =====
// Top level of the left/top average predictor decode block
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------
//  input     | push / full         | residual[7:0]
//  result    | empty / pop         | sample[7:0], end_of_row, end_of_frame
//  config    | psel/penable/pwrite | paddr[3:0], pwdata/prdata[31:0]
//
// One residual beat per cycle is taken while full is low; each sample passes
// through the command queue, the line store read stage and the result queue.
// Throughput is one beat per cycle unless a queue is full: stage 2 retires
// as the next sample issues, and a sample in the column just retired takes its
// top value from a bypass. Pad beats are consumed and give no result.
// Reset clears counters and queues at once; the line store is not cleared.
// Either side may stall: full rises when the command queue fills.
module average_predictor_raster_decode #(
	parameter int MAX_WIDTH = apr_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 residual,
	output logic                       empty,
	input  logic                       pop,
	output logic [7:0]                 sample,
	output logic                       end_of_row,
	output logic                       end_of_frame,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [apr_pkg::APB_AW-1:0] paddr,
	input  logic [apr_pkg::APB_DW-1:0] pwdata,
	output logic [apr_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import apr_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int CMDW = $bits(cmd_t) + XW;

	logic [12:0]   image_width_q;
	logic [15:0]   image_height_q;
	logic          pad_odd_rows_q;
	reg_idx_t      reg_idx;
	logic          cfg_wr;

	logic          cmd_push;
	cmd_t          cmd_in;
	logic [XW-1:0] xi_in;
	logic          cmd_full;
	logic          cmd_pop;
	logic          cmd_empty;
	logic [CMDW-1:0] cmd_out;
	cmd_t          cmd_head;
	logic [XW-1:0] xi_head;

	logic          res_push;
	res_t          res_in;
	logic          res_full;
	res_t          res_out;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 13'd1;
			image_height_q <= 16'd1;
			pad_odd_rows_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[12:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[15:0];
				REG_PAD_ODD_ROWS: pad_odd_rows_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height_q);
			REG_PAD_ODD_ROWS: prdata = APB_DW'(pad_odd_rows_q);
			default:          prdata = '0;
		endcase
	end

	// front end
	apr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.residual     (residual),
		.full         (full),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.pad_odd_rows (pad_odd_rows_q),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in),
		.cmd_xi       (xi_in),
		.cmd_full     (cmd_full)
	);

	// command queue between front and back
	apr_fifo #(.W(CMDW), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    ({cmd_in, xi_in}),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	assign cmd_head = cmd_t'(cmd_out[CMDW-1:XW]);
	assign xi_head  = cmd_out[XW-1:0];

	// back end
	apr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_xi    (xi_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	// result queue
	apr_fifo #(.W($bits(res_t)), .DEPTH(RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign sample       = res_out.sample;
	assign end_of_row   = res_out.eor;
	assign end_of_frame = res_out.eof;

endmodule

// ===== tb/average_predictor_raster_decode_tb.sv =====
// Self-checking testbench for the left/top average predictor decode block
module average_predictor_raster_decode_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import apr_pkg::*;

	localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
	localparam int RANDOM_BEATS  = 1900;
	localparam int CALM_FROM     = 1700;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int REPORT_LIMIT  = 10;

	// kinds of row in the directed script
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TYPED,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		reg_idx_t  idx;
		logic [31:0] value;
		res_t      want;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [7:0]          residual;
	logic                empty;
	logic                pop;
	logic [7:0]          sample;
	logic                end_of_row;
	logic                end_of_frame;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// decoder state mirrored by the predictor
	logic [12:0]         cfg_width  = 13'd1;
	logic [15:0]         cfg_height = 16'd1;
	logic                cfg_pad    = 1'b0;
	logic [7:0]          line_store [LINE_DEPTH];
	logic [7:0]          left_val   = 8'd0;
	int unsigned         col_idx    = 0;
	int unsigned         row_idx    = 0;
	bit                  pad_owed   = 0;

	res_t                expected_samples [$];
	script_row_t         script [$];
	int                  samples_sent = 0;
	int                  mismatches   = 0;
	int                  quiet_cycles = 0;
	bit                  send_idle    = 0;
	bit                  recv_idle    = 0;

	average_predictor_raster_decode u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.residual     (residual),
		.empty        (empty),
		.pop          (pop),
		.sample       (sample),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned eff_width();
		if (cfg_width == 13'd0)
			return 1;
		if (cfg_width > LINE_DEPTH)
			return LINE_DEPTH;
		return 32'(cfg_width);
	endfunction

	function automatic script_row_t script_row(row_kind_t kind, reg_idx_t idx,
			logic [31:0] value, logic [7:0] s, logic eor, logic eof);
		script_row_t r;
		r.kind = kind;
		r.idx = idx;
		r.value = value;
		r.want.sample = s;
		r.want.eor = eor;
		r.want.eof = eof;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// one residual beat through the predictor; pad beats give nothing
	task automatic reconstruct(input logic [7:0] r, output bit produced, output res_t res);
		int unsigned w;
		int unsigned h;
		int unsigned xi;
		logic [7:0]  pred;
		logic [8:0]  sum;
		logic [7:0]  s;
		bit          eor;
		bit          eof;
		w = eff_width();
		h = (cfg_height == 16'd0) ? 1 : 32'(cfg_height);
		xi = col_idx % LINE_DEPTH;
		produced = 0;
		res = '0;
		if (pad_owed) begin
			pad_owed = 0;
			return;
		end
		if (col_idx == 0 && row_idx == 0) begin
			s = r;
		end else begin
			if (row_idx == 0) begin
				pred = left_val;
			end else if (col_idx == 0) begin
				pred = line_store[0];
			end else begin
				sum = {1'b0, left_val} + {1'b0, line_store[xi]};
				pred = sum[8:1];
			end
			s = pred - r;
		end
		line_store[xi] = s;
		left_val = s;
		eor = (col_idx >= w - 1);
		eof = eor && (row_idx >= h - 1);
		if (eor) begin
			col_idx = 0;
			row_idx = eof ? 0 : row_idx + 1;
			pad_owed = cfg_pad && w[0];
		end else begin
			col_idx = col_idx + 1;
		end
		produced = 1;
		res.sample = s;
		res.eor = eor;
		res.eof = eof;
	endtask

	// offer one beat, with an optional idle burst ahead of it
	task automatic send_residual(input logic [7:0] r, input bit typed, input res_t want);
		int   gap;
		bit   produced;
		res_t res;
		if (send_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		residual <= r;
		do @(posedge clk); while (full);
		reconstruct(r, produced, res);
		if (produced) begin
			expected_samples.push_back(typed ? want : res);
			samples_sent++;
		end
	endtask

	// stop offering beats and let everything in flight come out
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// register write, mirrored in the predictor, then read back
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] want;
		logic [31:0] rd;
		case (idx)
			REG_IMAGE_WIDTH: begin
				cfg_width = value[12:0];
				want = {19'd0, value[12:0]};
			end
			REG_IMAGE_HEIGHT: begin
				cfg_height = value[15:0];
				want = {16'd0, value[15:0]};
			end
			default: begin
				cfg_pad = value[0];
				want = {31'd0, value[0]};
			end
		endcase
		apb_access(1'b1, idx, value, rd);
		apb_access(1'b0, idx, 32'd0, rd);
		if (rd !== want)
			flag_error($sformatf("register %s read %h, expected %h", idx.name(), rd, want));
	endtask

	// result side: random stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// compare each popped beat with the oldest expectation
	always @(posedge clk) begin : check_result
		res_t want;
		if (arst_n && pop && !empty) begin
			if (expected_samples.size() == 0) begin
				flag_error($sformatf("unexpected beat: got %02h/%0b/%0b",
					sample, end_of_row, end_of_frame));
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want.sample || end_of_row !== want.eor ||
						end_of_frame !== want.eof)
					flag_error($sformatf("sample/eor/eof expected %02h/%0b/%0b got %02h/%0b/%0b",
						want.sample, want.eor, want.eof,
						sample, end_of_row, end_of_frame));
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		script_row_t row;
		bit          mid_frame;
		logic [12:0] w;
		logic [15:0] h;
		logic        pad;
		int unsigned ew;
		int unsigned eh;
		int unsigned frame_bytes;
		int unsigned n;

		arst_n = 1'b0;
		push = 1'b0;
		residual = 8'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// reset settings: one-sample frames, first sample passes through
		script.push_back(script_row(ROW_TYPED, REG_IMAGE_WIDTH, 32'h00, 8'h00, 1'b1, 1'b1));
		script.push_back(script_row(ROW_TYPED, REG_IMAGE_WIDTH, 32'hFF, 8'hFF, 1'b1, 1'b1));
		// 3x2 with padding: top row, left column, inner, pad after each row
		script.push_back(script_row(ROW_WRITE, REG_IMAGE_WIDTH, 32'd3, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_WRITE, REG_IMAGE_HEIGHT, 32'd2, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_WRITE, REG_PAD_ODD_ROWS, 32'd1, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_TYPED, REG_IMAGE_WIDTH, 32'h10, 8'h10, 1'b0, 1'b0));
		script.push_back(script_row(ROW_TYPED, REG_IMAGE_WIDTH, 32'h20, 8'hF0, 1'b0, 1'b0));
		script.push_back(script_row(ROW_TYPED, REG_IMAGE_WIDTH, 32'hFF, 8'hF1, 1'b1, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'hAA, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h01, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h00, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h80, 8'h00, 1'b0, 1'b0));
		// pad owed by the last row, taken after the frame end
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h55, 8'h00, 1'b0, 1'b0));
		// zero width and height act as one; padding still on
		script.push_back(script_row(ROW_WRITE, REG_IMAGE_WIDTH, 32'd0, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_WRITE, REG_IMAGE_HEIGHT, 32'd0, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_TYPED, REG_IMAGE_WIDTH, 32'h7E, 8'h7E, 1'b1, 1'b1));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h00, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_TYPED, REG_IMAGE_WIDTH, 32'h81, 8'h81, 1'b1, 1'b1));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'hC3, 8'h00, 1'b0, 1'b0));
		// tallest frame, then width and height lowered under the counters
		script.push_back(script_row(ROW_WRITE, REG_IMAGE_WIDTH, 32'd4, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_WRITE, REG_IMAGE_HEIGHT, 32'hFFFF, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_WRITE, REG_PAD_ODD_ROWS, 32'd0, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h3C, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'hA5, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h5A, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'hC3, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h0F, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'hF0, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_WRITE, REG_IMAGE_WIDTH, 32'd2, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h11, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_WRITE, REG_IMAGE_HEIGHT, 32'd1, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h22, 8'h00, 1'b0, 1'b0));
		script.push_back(script_row(ROW_PREDICT, REG_IMAGE_WIDTH, 32'h33, 8'h00, 1'b0, 1'b0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed script
		send_idle = ($urandom_range(0, 1) == 1);
		recv_idle = ($urandom_range(0, 1) == 1);
		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.value);
			end else begin
				send_residual(row.value[7:0], row.kind == ROW_TYPED, row.want);
			end
		end

		// random phases; width never grows inside a frame
		while (samples_sent < RANDOM_BEATS) begin
			settle();
			mid_frame = (col_idx != 0) || (row_idx != 0);
			send_idle = (samples_sent < CALM_FROM) && ($urandom_range(0, 1) == 1);
			recv_idle = (samples_sent < CALM_FROM) && ($urandom_range(0, 1) == 1);
			if (mid_frame) begin
				w = 13'($urandom_range(1, eff_width()));
			end else begin
				case ($urandom_range(0, 9))
					0: w = 13'd0;
					1: w = 13'($urandom_range(10, 40));
					// above the line store size: clipped to it
					2: w = 13'h1FFF;
					default: w = 13'($urandom_range(1, 9));
				endcase
			end
			case ($urandom_range(0, 9))
				0: h = 16'd0;
				1: h = 16'hFFFF;
				default: h = 16'($urandom_range(1, 6));
			endcase
			pad = 1'($urandom_range(0, 1));
			write_reg(REG_IMAGE_WIDTH, {19'd0, w});
			write_reg(REG_IMAGE_HEIGHT, {16'd0, h});
			write_reg(REG_PAD_ODD_ROWS, {31'd0, pad});

			ew = eff_width();
			eh = (h == 16'd0) ? 1 : 32'(h);
			frame_bytes = ew * eh + ((pad && ew[0]) ? eh : 0);
			n = frame_bytes * $urandom_range(1, 3);
			if (n > 240)
				n = 240;
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, n);
			repeat (n) send_residual(8'($urandom_range(0, 255)), 1'b0, '0);
		end

		// drain without idling
		send_idle = 0;
		recv_idle = 0;
		@(negedge clk);
		push <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_samples.size() != 0)
			flag_error($sformatf("%0d beats never arrived", expected_samples.size()));
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
